>>> sv/rtbs_pkg.sv
// ----------------------------------------------------------------------------
// Rigid tangent basis skinning package
// Shared widths, sequencer step table and interface structs between the
// top level and the multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rtbs_pkg;

   localparam int QW      = 18;
   localparam int ProdW   = 2 * QW;
   localparam int FracW   = 14;
   localparam int RndW    = ProdW - FracW;
   localparam int AccW    = RndW + 2;
   localparam int OffW    = 24;
   localparam int InfoW   = 25;
   localparam int StepW   = 5;
   localparam int DestW   = 4;
   localparam int SrcIdxW = 3;
   localparam int BoneIdxW = 4;

   localparam logic [StepW-1:0] LastStep = StepW'(24);

   localparam logic signed [AccW-1:0] QMax = AccW'(131071);
   localparam logic signed [AccW-1:0] QMin = -AccW'(131072);
   localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(8192);

   localparam logic ReqLoad  = 1'b0;
   localparam logic ReqBasis = 1'b1;

   typedef logic signed [QW-1:0] q_type;

   typedef struct packed {
      logic                valid;
      logic                xprod;
      logic [SrcIdxW-1:0]  a_idx;
      logic [BoneIdxW-1:0] b_idx;
      logic                first;
      logic                last;
      logic                negate;
      logic [DestW-1:0]    dest;
   } step_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic             negate;
      logic [DestW-1:0] dest;
   } mac_ctrl_type;

   typedef struct packed {
      logic             valid;
      logic [DestW-1:0] dest;
      q_type            value;
      logic             clip;
   } mac_res_type;

   function automatic step_type mk_step(input logic xprod, input int a, input int b,
                                        input logic first, input logic last,
                                        input logic negate, input int dest);
      step_type s;
      s.valid  = 1'b1;
      s.xprod  = xprod;
      s.a_idx  = SrcIdxW'(a);
      s.b_idx  = BoneIdxW'(b);
      s.first  = first;
      s.last   = last;
      s.negate = negate;
      s.dest   = DestW'(dest);
      return s;
   endfunction

   // Transform steps multiply a source component by a bone entry; cross steps
   // multiply a transformed tangent component by a transformed binormal one.
   // Step 18 is a bubble so the last binormal component is written back first.
   function automatic step_type step_lookup(input logic [StepW-1:0] k);
      step_type s;
      s = '0;
      case (k)
         5'd0:  s = mk_step(1'b0, 0, 0, 1'b1, 1'b0, 1'b0, 0);
         5'd1:  s = mk_step(1'b0, 1, 3, 1'b0, 1'b0, 1'b0, 0);
         5'd2:  s = mk_step(1'b0, 2, 6, 1'b0, 1'b1, 1'b0, 0);
         5'd3:  s = mk_step(1'b0, 0, 1, 1'b1, 1'b0, 1'b0, 1);
         5'd4:  s = mk_step(1'b0, 1, 4, 1'b0, 1'b0, 1'b0, 1);
         5'd5:  s = mk_step(1'b0, 2, 7, 1'b0, 1'b1, 1'b0, 1);
         5'd6:  s = mk_step(1'b0, 0, 2, 1'b1, 1'b0, 1'b0, 2);
         5'd7:  s = mk_step(1'b0, 1, 5, 1'b0, 1'b0, 1'b0, 2);
         5'd8:  s = mk_step(1'b0, 2, 8, 1'b0, 1'b1, 1'b0, 2);
         5'd9:  s = mk_step(1'b0, 3, 0, 1'b1, 1'b0, 1'b0, 3);
         5'd10: s = mk_step(1'b0, 4, 3, 1'b0, 1'b0, 1'b0, 3);
         5'd11: s = mk_step(1'b0, 5, 6, 1'b0, 1'b1, 1'b0, 3);
         5'd12: s = mk_step(1'b0, 3, 1, 1'b1, 1'b0, 1'b0, 4);
         5'd13: s = mk_step(1'b0, 4, 4, 1'b0, 1'b0, 1'b0, 4);
         5'd14: s = mk_step(1'b0, 5, 7, 1'b0, 1'b1, 1'b0, 4);
         5'd15: s = mk_step(1'b0, 3, 2, 1'b1, 1'b0, 1'b0, 5);
         5'd16: s = mk_step(1'b0, 4, 5, 1'b0, 1'b0, 1'b0, 5);
         5'd17: s = mk_step(1'b0, 5, 8, 1'b0, 1'b1, 1'b0, 5);
         5'd19: s = mk_step(1'b1, 1, 2, 1'b1, 1'b0, 1'b0, 6);
         5'd20: s = mk_step(1'b1, 2, 1, 1'b0, 1'b1, 1'b1, 6);
         5'd21: s = mk_step(1'b1, 2, 0, 1'b1, 1'b0, 1'b0, 7);
         5'd22: s = mk_step(1'b1, 0, 2, 1'b0, 1'b1, 1'b1, 7);
         5'd23: s = mk_step(1'b1, 0, 1, 1'b1, 1'b0, 1'b0, 8);
         5'd24: s = mk_step(1'b1, 1, 0, 1'b0, 1'b1, 1'b1, 8);
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> sv/rtbs_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One registered 18x18 multiply, then rounding to Q3.14, signed accumulation
// and saturation of each finished sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbs_mac
   import rtbs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mac_ctrl_type issue,
   input  wire q_type        op_a,
   input  wire q_type        op_b,
   output mac_res_type       result
);

   logic signed [ProdW-1:0] prod_ff;
   mac_ctrl_type            ctrl_ff;
   logic signed [AccW-1:0]  acc_ff;

   logic signed [ProdW-1:0] biased;
   logic signed [RndW-1:0]  rnd;
   logic signed [AccW-1:0]  term;
   logic signed [AccW-1:0]  acc_in;

   always_ff @(posedge clock) begin
      prod_ff <= ProdW'(op_a) * ProdW'(op_b);
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= issue;
      end
      if (ctrl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      biased = prod_ff + RoundHalf;
      rnd    = biased[ProdW-1:FracW];
      term   = ctrl_ff.negate ? -AccW'(rnd) : AccW'(rnd);
      acc_in = (ctrl_ff.first ? AccW'(0) : acc_ff) + term;

      result.valid = ctrl_ff.valid && ctrl_ff.last;
      result.dest  = ctrl_ff.dest;
      result.clip  = 1'b0;
      if (acc_in > QMax) begin
         result.value = QMax[QW-1:0];
         result.clip  = 1'b1;
      end else if (acc_in < QMin) begin
         result.value = QMin[QW-1:0];
         result.clip  = 1'b1;
      end else begin
         result.value = acc_in[QW-1:0];
      end
   end

endmodule

`default_nettype wire

>>> sv/rigid_tangent_basis_skinning_top.sv
// ----------------------------------------------------------------------------
// Rigid tangent basis skinning
// Rotates tangent and binormal by one bone's 3x3 matrix and forms the normal
// as their cross product (negated when the flip bit of req_basis_info is set), in saturated signed Q3.14.
// ----------------------------------------------------------------------------
// A load word writes one matrix row and is taken in its accept cycle, so loads
// can follow back to back. A basis word runs through one shared 18x18
// multiplier: 24 products plus one bubble, then a flush state that drains the
// accumulator and a hold state that hands the result off; req_stall stays high
// after a basis word is accepted until the block is idle again. The finished
// result sits in an output register, so the next word is taken while it waits
// on rsp_stall; the hold state stretches only while an earlier result is still
// held there.
`default_nettype none

module rigid_tangent_basis_skinning_top
   import rtbs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_type,
   input  wire logic [1:0]       req_row_select,
   input  wire q_type            req_row_x,
   input  wire q_type            req_row_y,
   input  wire q_type            req_row_z,
   input  wire q_type            req_tangent_x,
   input  wire q_type            req_tangent_y,
   input  wire q_type            req_tangent_z,
   input  wire q_type            req_binormal_x,
   input  wire q_type            req_binormal_y,
   input  wire q_type            req_binormal_z,
   input  wire logic [InfoW-1:0] req_basis_info,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [OffW-1:0]       rsp_dest_offset,
   output q_type                 rsp_out_tangent_x,
   output q_type                 rsp_out_tangent_y,
   output q_type                 rsp_out_tangent_z,
   output q_type                 rsp_out_binormal_x,
   output q_type                 rsp_out_binormal_y,
   output q_type                 rsp_out_binormal_z,
   output q_type                 rsp_out_normal_x,
   output q_type                 rsp_out_normal_y,
   output q_type                 rsp_out_normal_z,
   output logic                  rsp_saturated
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [StepW-1:0]   step_ff;
   q_type              bone_ff [9];
   q_type              src_ff [6];
   q_type              tt_ff [3];
   q_type              bb_ff [3];
   q_type              nn_ff [3];
   logic               flip_ff;
   logic               clip_ff;
   logic [OffW-1:0]    offset_ff;

   logic               rsp_valid_ff;
   logic [OffW-1:0]    out_offset_ff;
   q_type              out_tt_ff [3];
   q_type              out_bb_ff [3];
   q_type              out_nn_ff [3];
   logic               out_clip_ff;

   logic               accept;
   logic               out_free;
   logic               load_out;
   step_type           tbl;
   mac_ctrl_type       issue;
   q_type              op_a;
   q_type              op_b;
   mac_res_type        res;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == ST_HOLD) && out_free;

   always_comb begin
      tbl          = step_lookup(step_ff);
      issue.valid  = (state_ff == ST_RUN) && tbl.valid;
      issue.first  = tbl.first;
      issue.last   = tbl.last;
      issue.negate = tbl.negate ^ (tbl.xprod & flip_ff);
      issue.dest   = tbl.dest;
      op_a = tbl.xprod ? tt_ff[tbl.a_idx[1:0]] : src_ff[tbl.a_idx];
      op_b = tbl.xprod ? bb_ff[tbl.b_idx[1:0]] : bone_ff[tbl.b_idx];
   end

   rtbs_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == ReqBasis) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_ff == LastStep) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_HOLD;
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            bone_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RUN) begin
            step_ff <= step_ff + StepW'(1);
         end else begin
            step_ff <= '0;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && req_type == ReqLoad) begin
            case (req_row_select)
               2'd0: begin
                  bone_ff[0] <= req_row_x;
                  bone_ff[1] <= req_row_y;
                  bone_ff[2] <= req_row_z;
               end
               2'd1: begin
                  bone_ff[3] <= req_row_x;
                  bone_ff[4] <= req_row_y;
                  bone_ff[5] <= req_row_z;
               end
               2'd2: begin
                  bone_ff[6] <= req_row_x;
                  bone_ff[7] <= req_row_y;
                  bone_ff[8] <= req_row_z;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_type == ReqBasis) begin
         src_ff[0] <= req_tangent_x;
         src_ff[1] <= req_tangent_y;
         src_ff[2] <= req_tangent_z;
         src_ff[3] <= req_binormal_x;
         src_ff[4] <= req_binormal_y;
         src_ff[5] <= req_binormal_z;
         flip_ff   <= req_basis_info[OffW];
         offset_ff <= req_basis_info[OffW-1:0];
         clip_ff   <= 1'b0;
      end else if (res.valid && res.clip) begin
         clip_ff <= 1'b1;
      end
      if (res.valid) begin
         for (int i = 0; i < 3; i++) begin
            if (res.dest == DestW'(i)) begin
               tt_ff[i] <= res.value;
            end
            if (res.dest == DestW'(i + 3)) begin
               bb_ff[i] <= res.value;
            end
            if (res.dest == DestW'(i + 6)) begin
               nn_ff[i] <= res.value;
            end
         end
      end
      if (load_out) begin
         out_offset_ff <= offset_ff;
         out_clip_ff   <= clip_ff;
         for (int i = 0; i < 3; i++) begin
            out_tt_ff[i] <= tt_ff[i];
            out_bb_ff[i] <= bb_ff[i];
            out_nn_ff[i] <= nn_ff[i];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dest_offset    = out_offset_ff;
   assign rsp_out_tangent_x  = out_tt_ff[0];
   assign rsp_out_tangent_y  = out_tt_ff[1];
   assign rsp_out_tangent_z  = out_tt_ff[2];
   assign rsp_out_binormal_x = out_bb_ff[0];
   assign rsp_out_binormal_y = out_bb_ff[1];
   assign rsp_out_binormal_z = out_bb_ff[2];
   assign rsp_out_normal_x   = out_nn_ff[0];
   assign rsp_out_normal_y   = out_nn_ff[1];
   assign rsp_out_normal_z   = out_nn_ff[2];
   assign rsp_saturated      = out_clip_ff;

endmodule

`default_nettype wire

>>> sv/rtbs_checker.sv
// ----------------------------------------------------------------------------
// Rigid tangent basis skinning port checker
// Watches the top level's ports for sequencing and hand-off rules.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbs_checker
   import rtbs_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire logic            req_type,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire logic [OffW-1:0] rsp_dest_offset
);

   // A basis word keeps the block busy on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == ReqBasis |=> req_stall)
      else $error("block took a word right after a basis word");

   // A load word leaves the block ready for the next word.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == ReqLoad |=> !req_stall)
      else $error("load word left the block busy");

   // A new result only appears at the end of a basis sequence.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared without a basis sequence");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dest_offset))
      else $error("stalled result word changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind rigid_tangent_basis_skinning_top rtbs_checker u_rtbs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_dest_offset (rsp_dest_offset)
);

`default_nettype wire
